// ===== hdl/qstm_pkg.sv =====
// shared widths, types and arithmetic helpers for the quaternion transform pipeline
package qstm_pkg;

  localparam int QW      = 16;
  localparam int MW      = 32;
  localparam int SQW     = 2 * QW;
  localparam int ENTRY_W = SQW + 2;
  localparam int PROD_W  = ENTRY_W + QW;
  localparam int DROP    = 22;

  typedef logic signed [QW-1:0]      quat_t;
  typedef logic signed [MW-1:0]      word_t;
  typedef logic signed [SQW-1:0]     sq_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam entry_t ONE_Q30  = entry_t'(64'sd1 <<< 30);
  localparam prod_t  HALF_LSB = prod_t'(64'sd1 <<< (DROP - 1));

  // 1 - 2(a+b) in q.30
  function automatic entry_t diag_entry(input sq_t a, input sq_t b);
    entry_t sum;
    sum = entry_t'(a) + entry_t'(b);
    return ONE_Q30 - (sum <<< 1);
  endfunction

  // 2(a+b) or 2(a-b) in q.30
  function automatic entry_t off_entry(input sq_t a, input sq_t b, input logic sub);
    entry_t sum;
    sum = sub ? (entry_t'(a) - entry_t'(b)) : (entry_t'(a) + entry_t'(b));
    return sum <<< 1;
  endfunction

  // q.38 to q16.16, round half up; the 28-bit result always fits so the clamp is a sign extend
  function automatic word_t round_q16(input prod_t p);
    prod_t s;
    s = p + HALF_LSB;
    return word_t'($signed(s[PROD_W-1:DROP]));
  endfunction

endpackage

// ===== hdl/quaternion_scale_translate_to_matrix.sv =====
// quaternion, scale and translation to the rotation-scale part of a trs matrix
// Takes one item per clock whenever start is high; busy is always low. Each item gives one
// result, marked by done, once it has passed through the stages: stage one forms the nine
// quaternion products, stage two the nine q.30 rotation entries, stage three the products
// with the axis scales and stage four the rounded q16.16 entries. Results cannot be held off,
// so the pipeline never stalls and a result is on the ports for one cycle only. Entries are
// column by column (mCR), rounded half up; translations pass through unchanged.
module quaternion_scale_translate_to_matrix (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  qstm_pkg::quat_t quat_x,
  input  qstm_pkg::quat_t quat_y,
  input  qstm_pkg::quat_t quat_z,
  input  qstm_pkg::quat_t quat_w,
  input  qstm_pkg::quat_t scale_x,
  input  qstm_pkg::quat_t scale_y,
  input  qstm_pkg::quat_t scale_z,
  input  qstm_pkg::word_t move_x,
  input  qstm_pkg::word_t move_y,
  input  qstm_pkg::word_t move_z,
  output logic           done,
  output qstm_pkg::word_t m00,
  output qstm_pkg::word_t m01,
  output qstm_pkg::word_t m02,
  output qstm_pkg::word_t m10,
  output qstm_pkg::word_t m11,
  output qstm_pkg::word_t m12,
  output qstm_pkg::word_t m20,
  output qstm_pkg::word_t m21,
  output qstm_pkg::word_t m22,
  output qstm_pkg::word_t out_move_x,
  output qstm_pkg::word_t out_move_y,
  output qstm_pkg::word_t out_move_z
);
  import qstm_pkg::*;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } move_t;

  logic   v1, v2, v3;
  sq_t    xx, yy, zz, xy, xz, yz, xw, yw, zw;
  quat_t  s1_scale [3];
  move_t  s1_move, s2_move, s3_move;
  entry_t ent [9];
  quat_t  s2_scale [3];
  prod_t  prod [9];
  word_t  res [9];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // stage 1: quaternion products
  always_ff @(posedge clk) begin
    xx <= sq_t'(quat_x * quat_x);
    yy <= sq_t'(quat_y * quat_y);
    zz <= sq_t'(quat_z * quat_z);
    xy <= sq_t'(quat_x * quat_y);
    xz <= sq_t'(quat_x * quat_z);
    yz <= sq_t'(quat_y * quat_z);
    xw <= sq_t'(quat_x * quat_w);
    yw <= sq_t'(quat_y * quat_w);
    zw <= sq_t'(quat_z * quat_w);
    s1_scale[0] <= scale_x;
    s1_scale[1] <= scale_y;
    s1_scale[2] <= scale_z;
    s1_move <= '{x: move_x, y: move_y, z: move_z};
  end

  // stage 2: rotation entries
  always_ff @(posedge clk) begin
    ent[0] <= diag_entry(yy, zz);
    ent[1] <= off_entry(xy, zw, 1'b0);
    ent[2] <= off_entry(xz, yw, 1'b1);
    ent[3] <= off_entry(xy, zw, 1'b1);
    ent[4] <= diag_entry(xx, zz);
    ent[5] <= off_entry(yz, xw, 1'b0);
    ent[6] <= off_entry(xz, yw, 1'b0);
    ent[7] <= off_entry(yz, xw, 1'b1);
    ent[8] <= diag_entry(xx, yy);
    s2_scale <= s1_scale;
    s2_move  <= s1_move;
  end

  // stage 3: column scaling
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      prod[i] <= prod_t'(ent[i] * s2_scale[i / 3]);
    end
    s3_move <= s2_move;
  end

  // stage 4: rounding
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      res[i] <= round_q16(prod[i]);
    end
    out_move_x <= s3_move.x;
    out_move_y <= s3_move.y;
    out_move_z <= s3_move.z;
  end

  assign m00 = res[0];
  assign m01 = res[1];
  assign m02 = res[2];
  assign m10 = res[3];
  assign m11 = res[4];
  assign m12 = res[5];
  assign m20 = res[6];
  assign m21 = res[7];
  assign m22 = res[8];

  a_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##4 done)
    else $error("accepted item produced no result");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst) done |-> $past(start, 4))
    else $error("result without accepted item");

  a_move: assert property (@(posedge clk) disable iff (rst)
      done |-> (out_move_x == $past(move_x, 4)) && (out_move_y == $past(move_y, 4)) &&
               (out_move_z == $past(move_z, 4)))
    else $error("translation not passed through");

  a_busy: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("item refused");

endmodule
